// File: design/ornt_pkg.sv
// shared types, constants and hash functions for the ordered name record table
package ornt_pkg;

  localparam int ENTRIES    = 64;
  localparam int NAME_BYTES = 64;
  localparam int NAME_W     = NAME_BYTES * 8;
  localparam int BC_W       = $clog2(NAME_BYTES + 1);
  localparam int NB_W       = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CMP,
    CMD_INS,
    CMD_DEL,
    CMD_UPD
  } cmd_e;

  typedef struct packed {
    logic              valid;
    logic [31:0]       hash;
    logic [31:0]       salary;
    logic [NAME_W-1:0] name;
  } entry_t;

  typedef struct packed {
    cmd_e              op;
    logic [31:0]       key;
    logic [31:0]       salary;
    logic [NAME_W-1:0] name;
  } cell_cmd_t;

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] hash_final(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

// File: design/ornt_cell.sv
// one table slot: holds a record, compares it and shifts with its neighbors
module ornt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ornt_pkg::cell_cmd_t cmd_i,
  input  ornt_pkg::entry_t   left_i,
  input  ornt_pkg::entry_t   right_i,
  input  logic               left_gt_i,
  input  logic               del_here_i,
  output ornt_pkg::entry_t   ent_o,
  output logic               gt_o,
  output logic               match_o,
  output logic [31:0]        sal_o
);

  logic                        valid_q, valid_d;
  logic [31:0]                 hash_q, hash_d;
  logic [31:0]                 sal_q, sal_d;
  logic [ornt_pkg::NAME_W-1:0] name_q, name_d;
  logic                        gt_q, match_q;

  always_comb begin
    valid_d = valid_q;
    hash_d  = hash_q;
    sal_d   = sal_q;
    name_d  = name_q;
    case (cmd_i.op)
      ornt_pkg::CMD_INS: begin
        if (gt_q) begin
          if (left_gt_i) begin
            valid_d = left_i.valid;
            hash_d  = left_i.hash;
            sal_d   = left_i.salary;
            name_d  = left_i.name;
          end else begin
            valid_d = 1'b1;
            hash_d  = cmd_i.key;
            sal_d   = cmd_i.salary;
            name_d  = cmd_i.name;
          end
        end
      end
      ornt_pkg::CMD_DEL: begin
        if (del_here_i) begin
          valid_d = right_i.valid;
          hash_d  = right_i.hash;
          sal_d   = right_i.salary;
          name_d  = right_i.name;
        end
      end
      ornt_pkg::CMD_UPD: begin
        if (match_q) sal_d = cmd_i.salary;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.op == ornt_pkg::CMD_CMP) begin
        match_q <= valid_q && (hash_q == cmd_i.key) && (name_q == cmd_i.name);
        gt_q    <= !valid_q || (hash_q > cmd_i.key);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    sal_q  <= sal_d;
    name_q <= name_d;
  end

  assign ent_o   = '{valid: valid_q, hash: hash_q, salary: sal_q, name: name_q};
  assign gt_o    = gt_q;
  assign match_o = match_q;
  assign sal_o   = match_q ? sal_q : 32'd0;

endmodule

// File: design/ordered_name_record_table.sv
// top level: name hashing, request control and the sorted row of record cells
//
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | req_type_i name_byte_i name_last_i salary_in_i
// out     | output    | out_valid_o/out_ready_i | status_o salary_out_o key_hash_o
//
// name bytes are taken while the table is idle; after the last byte the request
// goes through finalize, compare in all cells, apply and result before the next request is taken.
// the result register holds until it is taken; no input is taken meanwhile.
// reset clears the cell valid bits and the request state at once.
module ordered_name_record_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  name_byte_i,
  input  logic        name_last_i,
  input  logic [31:0] salary_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] salary_out_o,
  output logic [31:0] key_hash_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIN,
    S_CMP,
    S_EXEC,
    S_OUT
  } state_e;

  localparam int E = ornt_pkg::ENTRIES;

  state_e                    state_q;
  logic [31:0]               hash_q, key_q, sal_req_q;
  logic [1:0]                req_q;
  logic                      done_q;
  logic [ornt_pkg::BC_W-1:0] count_q;
  logic [7:0]                req_name_q [ornt_pkg::NAME_BYTES];
  logic [ornt_pkg::NAME_W-1:0] name_masked;
  logic [2:0]                status_q;
  logic [31:0]               sal_out_q;

  ornt_pkg::entry_t    ent   [E];
  logic                gt    [E];
  logic                match [E];
  logic [31:0]         sal   [E];
  logic                del_pre [E];
  ornt_pkg::cell_cmd_t cmd;

  logic        found;
  logic [31:0] found_sal;
  logic        full;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  // bytes past the stored count read as zero
  always_comb begin
    for (int j = 0; j < ornt_pkg::NAME_BYTES; j++) begin
      name_masked[j*8 +: 8] = (ornt_pkg::BC_W'(j) < count_q) ? req_name_q[j] : 8'd0;
    end
  end

  always_comb begin
    found     = 1'b0;
    found_sal = 32'd0;
    for (int i = 0; i < E; i++) begin
      found     = found | match[i];
      found_sal = found_sal | sal[i];
    end
  end

  assign full = ent[E-1].valid;

  always_comb begin
    cmd.key    = key_q;
    cmd.salary = sal_req_q;
    cmd.name   = name_masked;
    cmd.op     = ornt_pkg::CMD_NONE;
    case (state_q)
      S_CMP: cmd.op = ornt_pkg::CMD_CMP;
      S_EXEC: begin
        if (req_q == ornt_pkg::REQ_INSERT) begin
          if (found) cmd.op = ornt_pkg::CMD_UPD;
          else if (!full) cmd.op = ornt_pkg::CMD_INS;
        end else if (req_q == ornt_pkg::REQ_DELETE && found) begin
          cmd.op = ornt_pkg::CMD_DEL;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < E; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign del_pre[i] = match[i];
    end else begin : g_rest
      assign del_pre[i] = del_pre[i-1] | match[i];
    end
    ornt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .left_i     ((i == 0) ? '0 : ent[(i == 0) ? 0 : i-1]),
      .right_i    ((i == E-1) ? '0 : ent[(i == E-1) ? i : i+1]),
      .left_gt_i  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .del_here_i (del_pre[i]),
      .ent_o      (ent[i]),
      .gt_o       (gt[i]),
      .match_o    (match[i]),
      .sal_o      (sal[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept && !done_q && name_byte_i != 8'd0 &&
        count_q < ornt_pkg::BC_W'(ornt_pkg::NAME_BYTES)) begin
      req_name_q[count_q[ornt_pkg::NB_W-1:0]] <= name_byte_i;
    end
    if (accept && name_last_i) begin
      req_q     <= req_type_i;
      sal_req_q <= salary_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hash_q    <= 32'd0;
      key_q     <= 32'd0;
      done_q    <= 1'b0;
      count_q   <= '0;
      status_q  <= ornt_pkg::ST_NOT_FOUND;
      sal_out_q <= 32'd0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!done_q) begin
              if (name_byte_i == 8'd0) begin
                done_q <= 1'b1;
              end else begin
                hash_q <= ornt_pkg::hash_step(hash_q, name_byte_i);
                if (count_q < ornt_pkg::BC_W'(ornt_pkg::NAME_BYTES)) count_q <= count_q + 1'b1;
              end
            end
            if (name_last_i) state_q <= S_FIN;
          end
        end
        S_FIN: begin
          key_q   <= ornt_pkg::hash_final(hash_q);
          state_q <= S_CMP;
        end
        S_CMP: state_q <= S_EXEC;
        S_EXEC: begin
          sal_out_q <= 32'd0;
          if (req_q == ornt_pkg::REQ_INSERT) begin
            if (found) begin
              status_q  <= ornt_pkg::ST_UPDATED;
              sal_out_q <= found_sal;
            end else if (full) begin
              status_q <= ornt_pkg::ST_FULL;
            end else begin
              status_q <= ornt_pkg::ST_INSERTED;
            end
          end else if (req_q == ornt_pkg::REQ_DELETE) begin
            status_q  <= found ? ornt_pkg::ST_DELETED : ornt_pkg::ST_NOT_FOUND;
            sal_out_q <= found_sal;
          end else begin
            status_q  <= found ? ornt_pkg::ST_FOUND : ornt_pkg::ST_NOT_FOUND;
            sal_out_q <= found_sal;
          end
          hash_q  <= 32'd0;
          done_q  <= 1'b0;
          count_q <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign status_o     = status_q;
  assign salary_out_o = sal_out_q;
  assign key_hash_o   = key_q;

endmodule
